>>> hdl/lrb_pkg.sv
// ============================================================================
// lrb_pkg
// Shared constants, types and the sequencer state encoding of the LRU record
// buffer.
// ============================================================================
package lrb_pkg;

  // Buffer geometry.
  localparam int ENTRIES   = 16;
  localparam int LINE_BITS = 24;

  // Fixed widths of the external fields.
  localparam int LINE_NUMBER_W  = 24;
  localparam int SLOT_W         = 4;
  localparam int EVICTED_LINE_W = 24;

  // Derived widths.
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [LINE_BITS-1:0] tag_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  // Memory requests from the engine to the tag and rank stores.
  typedef struct packed {
    idx_t  rd_addr;
    logic  tag_we;
    idx_t  tag_waddr;
    tag_t  tag_wdata;
    logic  rank_we;
    idx_t  rank_waddr;
    rank_t rank_wdata;
  } mem_req_t;

endpackage

>>> hdl/lru_record_buffer_core.sv
// ============================================================================
// lru_record_buffer_core
// Fully associative buffer of record line numbers with least-recently-used
// replacement, built around a tag store and a rank store.
// ============================================================================
// Usage:
//   Command channel: drive line_number and raise start; the beat is taken at
//   a rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
//   Result channel: done is high for exactly one cycle with hit, slot,
//   evicted and evicted_line valid in that cycle. The receiver cannot stall,
//   so the result must be captured in that cycle.
//   The next beat can be taken in the cycle after done. A lookup makes two
//   sweeps over the stores through one read port each: a search sweep over
//   tags and ranks, and a read-modify-write sweep that ages the ranks.
//   Reset (rst, synchronous) clears the valid bits and the occupancy count;
//   the stores themselves are not cleared, since an entry is only used once
//   it has been written. No clearing pass is needed, so the block takes a
//   beat in the first cycle after reset.
// ============================================================================
module lru_record_buffer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrb_pkg::LINE_NUMBER_W-1:0]   line_number,
  output logic                                done,
  output logic                                hit,
  output logic [lrb_pkg::SLOT_W-1:0]          slot,
  output logic                                evicted,
  output logic [lrb_pkg::EVICTED_LINE_W-1:0]  evicted_line
);

  import lrb_pkg::*;

  mem_req_t mem_req;
  tag_t     tag_rdata;
  rank_t    rank_rdata;

  // Sequencer and lookup datapath.
  lrb_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .line_number  (line_number),
    .done         (done),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_line (evicted_line),
    .mem_req      (mem_req),
    .tag_rdata    (tag_rdata),
    .rank_rdata   (rank_rdata)
  );

  // Tag store: one tag per slot.
  lrb_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (LINE_BITS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_req.tag_we),
    .waddr (mem_req.tag_waddr),
    .wdata (mem_req.tag_wdata),
    .raddr (mem_req.rd_addr),
    .rdata (tag_rdata)
  );

  // Rank store: recency rank per slot, zero being most recent.
  lrb_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (RANK_W)
  ) u_rank_ram (
    .clk   (clk),
    .we    (mem_req.rank_we),
    .waddr (mem_req.rank_waddr),
    .wdata (mem_req.rank_wdata),
    .raddr (mem_req.rd_addr),
    .rdata (rank_rdata)
  );

endmodule

>>> hdl/lrb_ram.sv
// ============================================================================
// lrb_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ============================================================================
module lrb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lrb_engine.sv
// ============================================================================
// lrb_engine
// Lookup sequencer: sweeps tag and rank stores for a hit, a free slot or the
// least recent entry, installs the tag on a miss, then sweeps the ranks to age
// all valid entries on a fill, else those more recent than the hit or victim.
// ============================================================================
module lrb_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrb_pkg::LINE_NUMBER_W-1:0]   line_number,
  output logic                                done,
  output logic                                hit,
  output logic [lrb_pkg::SLOT_W-1:0]          slot,
  output logic                                evicted,
  output logic [lrb_pkg::EVICTED_LINE_W-1:0]  evicted_line,
  output lrb_pkg::mem_req_t                   mem_req,
  input  lrb_pkg::tag_t                       tag_rdata,
  input  lrb_pkg::rank_t                      rank_rdata
);

  import lrb_pkg::*;

  state_t state, state_next;
  cnt_t   cnt, cnt_next;
  logic   rd_vld, rd_vld_next;
  idx_t   rd_idx, rd_idx_next;
  tag_t   tag_q, tag_q_next;

  logic   found, found_next;
  idx_t   hit_idx, hit_idx_next;
  rank_t  hit_rank, hit_rank_next;
  logic   free_found, free_found_next;
  idx_t   free_idx, free_idx_next;
  idx_t   best_idx, best_idx_next;
  rank_t  best_rank, best_rank_next;
  tag_t   best_tag, best_tag_next;

  idx_t   target, target_next;
  rank_t  limit, limit_next;
  logic   age_all, age_all_next;

  logic [ENTRIES-1:0] valid, valid_next;
  occ_t   occ, occ_next;

  logic                      hit_next;
  logic [SLOT_W-1:0]         slot_next;
  logic                      evicted_next;
  logic [EVICTED_LINE_W-1:0] evicted_line_next;

  logic   sweep_more;
  logic   rd_entry_valid;

  // The sweep counter runs from zero up to the entry count.
  assign sweep_more     = (cnt < CNT_W'(ENTRIES));
  assign rd_entry_valid = valid[rd_idx];

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_REPORT);

  // Next-state and datapath logic.
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    rd_vld_next       = 1'b0;
    rd_idx_next       = rd_idx;
    tag_q_next        = tag_q;
    found_next        = found;
    hit_idx_next      = hit_idx;
    hit_rank_next     = hit_rank;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    best_idx_next     = best_idx;
    best_rank_next    = best_rank;
    best_tag_next     = best_tag;
    target_next       = target;
    limit_next        = limit;
    age_all_next      = age_all;
    valid_next        = valid;
    occ_next          = occ;
    hit_next          = hit;
    slot_next         = slot;
    evicted_next      = evicted;
    evicted_line_next = evicted_line;

    mem_req            = '0;
    mem_req.rd_addr    = cnt[IDX_W-1:0];
    mem_req.tag_waddr  = target;
    mem_req.tag_wdata  = tag_q;
    mem_req.rank_waddr = rd_idx;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          tag_q_next      = LINE_BITS'(line_number);
          cnt_next        = '0;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          state_next      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle while entries remain.
        if (sweep_more) begin
          rd_vld_next = 1'b1;
          rd_idx_next = cnt[IDX_W-1:0];
          cnt_next    = cnt + CNT_W'(1);
        end
        // Examine the entry whose data has just returned.
        if (rd_vld) begin
          if (!found && rd_entry_valid && (tag_rdata == tag_q)) begin
            found_next    = 1'b1;
            hit_idx_next  = rd_idx;
            hit_rank_next = rank_rdata;
          end
          if (!free_found && !rd_entry_valid) begin
            free_found_next = 1'b1;
            free_idx_next   = rd_idx;
          end
          // Strictly greater keeps the lowest slot on equal ranks.
          if ((rd_idx == '0) || (rank_rdata > best_rank)) begin
            best_idx_next  = rd_idx;
            best_rank_next = rank_rdata;
            best_tag_next  = tag_rdata;
          end
          if (!sweep_more) begin
            state_next = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        cnt_next          = '0;
        hit_next          = found;
        evicted_next      = 1'b0;
        evicted_line_next = '0;
        age_all_next      = 1'b0;
        if (found) begin
          target_next = hit_idx;
          limit_next  = hit_rank;
          slot_next   = SLOT_W'(hit_idx);
        end else if (free_found) begin
          target_next         = free_idx;
          age_all_next        = 1'b1;
          slot_next           = SLOT_W'(free_idx);
          valid_next[free_idx] = 1'b1;
          if (occ < OCC_W'(ENTRIES)) begin
            occ_next = occ + OCC_W'(1);
          end
          mem_req.tag_we    = 1'b1;
          mem_req.tag_waddr = free_idx;
        end else begin
          target_next       = best_idx;
          limit_next        = best_rank;
          slot_next         = SLOT_W'(best_idx);
          evicted_next      = 1'b1;
          evicted_line_next = EVICTED_LINE_W'(best_tag);
          occ_next          = OCC_W'(ENTRIES);
          mem_req.tag_we    = 1'b1;
          mem_req.tag_waddr = best_idx;
        end
        state_next = ST_UPDATE;
      end

      ST_UPDATE: begin
        if (sweep_more) begin
          rd_vld_next = 1'b1;
          rd_idx_next = cnt[IDX_W-1:0];
          cnt_next    = cnt + CNT_W'(1);
        end
        // Read-modify-write of one rank per cycle; the write lands on the
        // entry read in the previous cycle, never on the one being read.
        if (rd_vld) begin
          if (rd_idx == target) begin
            mem_req.rank_we    = 1'b1;
            mem_req.rank_wdata = '0;
          end else if (rd_entry_valid && (age_all || (rank_rdata < limit))) begin
            mem_req.rank_we    = 1'b1;
            mem_req.rank_wdata = rank_rdata + RANK_W'(1);
          end
          if (!sweep_more) begin
            state_next = ST_REPORT;
          end
        end
      end

      ST_REPORT: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
      valid  <= '0;
      occ    <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
      valid  <= valid_next;
      occ    <= occ_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt          <= cnt_next;
    rd_idx       <= rd_idx_next;
    tag_q        <= tag_q_next;
    found        <= found_next;
    hit_idx      <= hit_idx_next;
    hit_rank     <= hit_rank_next;
    free_found   <= free_found_next;
    free_idx     <= free_idx_next;
    best_idx     <= best_idx_next;
    best_rank    <= best_rank_next;
    best_tag     <= best_tag_next;
    target       <= target_next;
    limit        <= limit_next;
    age_all      <= age_all_next;
    hit          <= hit_next;
    slot         <= slot_next;
    evicted      <= evicted_next;
    evicted_line <= evicted_line_next;
  end

  // The occupancy count always matches the number of valid entries.
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == occ)
    else $error("occupancy count differs from valid bits");

  // An eviction only happens on a full buffer, and never with a hit.
  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> (occ == OCC_W'(ENTRIES)) && !hit)
    else $error("eviction reported while not full or on a hit");

  // An accepted beat takes the engine out of idle on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN))
    else $error("accepted beat did not start a scan");

  // A result beat comes only at the end of the rank update sweep.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_UPDATE))
    else $error("result beat without a completed update sweep");

  // The update sweep never writes the rank it reads in the same cycle.
  a_no_rank_collision: assert property (@(posedge clk) disable iff (rst)
    mem_req.rank_we |-> (mem_req.rank_waddr != mem_req.rd_addr) || !sweep_more)
    else $error("rank write collides with a rank read");

endmodule
